/* hw/rtl/wrm_pkg.sv */
// ----------------------------------------------------------------------------
// wrm_pkg
// Shared types, widths and constants for the windowed rms / mean meter.
// ----------------------------------------------------------------------------
`default_nettype none

package wrm_pkg;

    // sizing
    localparam int SAMPLE_BITS = 14;
    localparam int COUNT_BITS  = 16;

    // register widths
    localparam int WLEN_W   = 16;
    localparam int OFFSET_W = 25;
    localparam int SCALE_W  = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;

    // result widths
    localparam int LVL_W = 23;
    localparam int CAL_W = 26;

    // datapath widths
    localparam int SUM_W      = 48;
    localparam int RMS_SHIFT  = 16;
    localparam int MEAN_SHIFT = 8;
    localparam int QUO_W      = SUM_W + RMS_SHIFT;
    localparam int ROOT_W     = QUO_W / 2;
    localparam int SUB_W      = ROOT_W + 3;
    localparam int REM_W      = SUB_W - 1;
    localparam int STEP_W     = $clog2(QUO_W);
    localparam int SQ_W       = 2 * (SAMPLE_BITS + 1);
    localparam int CMP_W      = (COUNT_BITS > WLEN_W) ? COUNT_BITS : WLEN_W;
    localparam int TOTAL_W    = CAL_W;
    localparam int PROD_W     = TOTAL_W + SCALE_W + 1;
    localparam int CAL_SHIFT  = 24;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic signed [LVL_W-1:0] LVL_MAX = {1'b0, {(LVL_W-1){1'b1}}};
    localparam logic signed [LVL_W-1:0] LVL_MIN = {1'b1, {(LVL_W-1){1'b0}}};

    // register reset values
    localparam logic [WLEN_W-1:0]          WLEN_RST   = WLEN_W'(6000);
    localparam logic [SAMPLE_BITS-1:0]     CENTER_RST = SAMPLE_BITS'(2067);
    localparam logic signed [OFFSET_W-1:0] OFFSET_RST = OFFSET_W'(579);
    localparam logic [SCALE_W-1:0]         SCALE_RST  = SCALE_W'(118609);

    localparam logic MODE_RMS  = 1'b0;
    localparam logic MODE_MEAN = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE   = 3'd0,
        CFG_WLEN   = 3'd1,
        CFG_CENTER = 3'd2,
        CFG_OFFSET = 3'd3,
        CFG_SCALE  = 3'd4
    } wrm_cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_DIV,
        ST_SQRT,
        ST_LVL,
        ST_MUL,
        ST_OUT
    } wrm_state_t;

endpackage

`default_nettype wire

/* hw/rtl/wrm_sample_if.sv */
// ----------------------------------------------------------------------------
// wrm_sample_if
// Valid/ready channel carrying one raw converter sample per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface wrm_sample_if
    import wrm_pkg::*;
    ();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

/* hw/rtl/wrm_result_if.sv */
// ----------------------------------------------------------------------------
// wrm_result_if
// Valid/ready channel carrying one window result per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface wrm_result_if
    import wrm_pkg::*;
    ();
    logic                    valid;
    logic                    ready;
    logic signed [LVL_W-1:0] level_q8;
    logic signed [CAL_W-1:0] calibrated;

    modport source (output valid, output level_q8, output calibrated, input ready);
    modport sink   (input valid, input level_q8, input calibrated, output ready);
endinterface

`default_nettype wire

/* hw/rtl/windowed_rms_mean_meter.sv */
// ----------------------------------------------------------------------------
// windowed_rms_mean_meter
// Centers raw samples, accumulates squares or values over a window and at
// window close emits the rms or mean level in Q8 plus a calibrated reading.
// ----------------------------------------------------------------------------
// a sample is captured, then squared/accumulated; before ready returns,
// a window close takes 64 divide steps, 32 more square root steps in rms mode,
// then level, multiply and output states; the divide and square root share
// one compare/subtract unit
// result waits in an output register; the next sample is taken meanwhile, but
// a close stalls in its output cycle while the previous result is unread
// reset clears sums, count and output valid and loads register defaults
`default_nettype none

module windowed_rms_mean_meter
    import wrm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    wrm_sample_if.sink                 din,
    wrm_result_if.source               dout,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration
    logic                       mode_reg;
    logic [WLEN_W-1:0]          wlen_reg;
    logic [SAMPLE_BITS-1:0]     center_reg;
    logic signed [OFFSET_W-1:0] offset_reg;
    logic [SCALE_W-1:0]         scale_reg;

    // control state
    wrm_state_t              state_reg, state_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic [COUNT_BITS-1:0]   count_reg, count_next;
    logic                    out_valid_reg, out_valid_next;

    // payload
    logic signed [SAMPLE_BITS:0] centered_reg, centered_next;
    logic [QUO_W-1:0]            num_reg, num_next;
    logic [REM_W-1:0]            rem_reg, rem_next;
    logic [ROOT_W-1:0]           root_reg, root_next;
    logic                        neg_reg, neg_next;
    logic signed [LVL_W-1:0]     level_reg, level_next;
    logic signed [PROD_W-1:0]    prod_reg, prod_next;
    logic signed [LVL_W-1:0]     out_level_reg, out_level_next;
    logic signed [CAL_W-1:0]     out_cal_reg, out_cal_next;

    // shared compare/subtract unit
    logic [SUB_W-1:0] sub_a, sub_b;
    logic [SUB_W:0]   sub_diff;
    logic             sub_ge;

    // accumulate helpers
    logic signed [SQ_W-1:0]  sq;
    logic [SUM_W-1:0]        acc_sum;
    logic [SUM_W-1:0]        acc_mag;
    logic [COUNT_BITS-1:0]   acc_count;
    logic                    acc_close;

    // level helpers
    logic                    mean_pos_sat, mean_neg_sat;
    logic signed [TOTAL_W-1:0] total;

    assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_ge   = ~sub_diff[SUB_W];

    assign sq        = centered_reg * centered_reg;
    assign acc_sum   = sum_reg + ((mode_reg == MODE_MEAN) ? SUM_W'(centered_reg)
                                 : {{(SUM_W-SQ_W){1'b0}}, sq});
    assign acc_mag   = acc_sum[SUM_W-1] ? (~acc_sum + 1'b1) : acc_sum;
    assign acc_count = (count_reg != COUNT_MAX) ? count_reg + 1'b1 : count_reg;
    assign acc_close = (CMP_W'(acc_count) >= CMP_W'(wlen_reg)) || (acc_count == COUNT_MAX);

    assign mean_pos_sat = |num_reg[QUO_W-1:LVL_W-1];
    assign mean_neg_sat = (|num_reg[QUO_W-1:LVL_W])
                          || (num_reg[LVL_W-1] && (|num_reg[LVL_W-2:0]));

    assign total = TOTAL_W'(level_reg) + TOTAL_W'(offset_reg);

    assign dout.valid      = out_valid_reg;
    assign dout.level_q8   = out_level_reg;
    assign dout.calibrated = out_cal_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_RMS;
            wlen_reg   <= WLEN_RST;
            center_reg <= CENTER_RST;
            offset_reg <= OFFSET_RST;
            scale_reg  <= SCALE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MODE:   mode_reg   <= cfg_data[0];
                CFG_WLEN:   wlen_reg   <= cfg_data[WLEN_W-1:0];
                CFG_CENTER: center_reg <= cfg_data[SAMPLE_BITS-1:0];
                CFG_OFFSET: offset_reg <= cfg_data[OFFSET_W-1:0];
                CFG_SCALE:  scale_reg  <= cfg_data[SCALE_W-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        centered_reg  <= centered_next;
        num_reg       <= num_next;
        rem_reg       <= rem_next;
        root_reg      <= root_next;
        neg_reg       <= neg_next;
        level_reg     <= level_next;
        prod_reg      <= prod_next;
        out_level_reg <= out_level_next;
        out_cal_reg   <= out_cal_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !dout.ready;
        centered_next  = centered_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        neg_next       = neg_reg;
        level_next     = level_reg;
        prod_next      = prod_reg;
        out_level_next = out_level_reg;
        out_cal_next   = out_cal_reg;
        sub_a          = '0;
        sub_b          = '0;
        din.ready      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                din.ready = 1'b1;
                if (din.valid)
                begin
                    centered_next = $signed({1'b0, din.sample}) - $signed({1'b0, center_reg});
                    state_next    = ST_ACC;
                end
            end

            ST_ACC:
            begin
                sum_next   = acc_sum;
                count_next = acc_count;
                if (acc_close)
                begin
                    rem_next  = '0;
                    step_next = '0;
                    neg_next  = (mode_reg == MODE_MEAN) && acc_sum[SUM_W-1];
                    if (mode_reg == MODE_MEAN)
                        num_next = QUO_W'({acc_mag, {MEAN_SHIFT{1'b0}}});
                    else
                        num_next = {acc_sum, {RMS_SHIFT{1'b0}}};
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            // restoring divide, one quotient bit per cycle
            ST_DIV:
            begin
                sub_a = SUB_W'({rem_reg[COUNT_BITS-1:0], num_reg[QUO_W-1]});
                sub_b = SUB_W'(count_reg);
                if (sub_ge)
                    rem_next = REM_W'(sub_diff[COUNT_BITS:0]);
                else
                    rem_next = REM_W'(sub_a[COUNT_BITS:0]);
                num_next  = {num_reg[QUO_W-2:0], sub_ge};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(QUO_W-1))
                begin
                    step_next = '0;
                    if (mode_reg == MODE_RMS)
                    begin
                        rem_next   = '0;
                        root_next  = '0;
                        state_next = ST_SQRT;
                    end
                    else
                    begin
                        state_next = ST_LVL;
                    end
                end
            end

            // digit-by-digit square root, two radicand bits per cycle
            ST_SQRT:
            begin
                sub_a = {rem_reg[SUB_W-3:0], num_reg[QUO_W-1:QUO_W-2]};
                sub_b = SUB_W'({root_reg, 2'b01});
                if (sub_ge)
                    rem_next = sub_diff[REM_W-1:0];
                else
                    rem_next = sub_a[REM_W-1:0];
                root_next = {root_reg[ROOT_W-2:0], sub_ge};
                num_next  = {num_reg[QUO_W-3:0], 2'b00};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(ROOT_W-1))
                begin
                    step_next  = '0;
                    state_next = ST_LVL;
                end
            end

            ST_LVL:
            begin
                if (mode_reg == MODE_RMS)
                    level_next = (|root_reg[ROOT_W-1:LVL_W-1]) ? LVL_MAX
                                 : $signed(root_reg[LVL_W-1:0]);
                else if (neg_reg)
                    level_next = mean_neg_sat ? LVL_MIN : -$signed(num_reg[LVL_W-1:0]);
                else
                    level_next = mean_pos_sat ? LVL_MAX : $signed(num_reg[LVL_W-1:0]);
                state_next = ST_MUL;
            end

            ST_MUL:
            begin
                prod_next  = total * $signed({1'b0, scale_reg});
                state_next = ST_OUT;
            end

            // wait for the output slot to free up
            ST_OUT:
            begin
                if (!out_valid_reg || dout.ready)
                begin
                    out_valid_next = 1'b1;
                    out_level_next = level_reg;
                    out_cal_next   = prod_reg[CAL_W+CAL_SHIFT-1:CAL_SHIFT];
                    sum_next       = '0;
                    count_next     = '0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the windowed rms / mean meter against an in-bench predictor of its
// window sums, level and calibrated reading. Directed tests cover register
// defaults, field extremes, shortened windows and mode changes inside a
// window. A long random run with random idling on both channels follows.
// Every result beat is compared field by field.
// ----------------------------------------------------------------------------

module tb_top;
    import wrm_pkg::*;

    localparam int     MAX_IDLE     = 18;
    localparam int     DRAIN_CYCLES = 120;
    localparam int     SAMPLE_MAX   = (1 << SAMPLE_BITS) - 1;
    localparam longint LVL_HI       = longint'(LVL_MAX);
    localparam longint LVL_LO       = longint'(LVL_MIN);
    localparam longint CAL_HI       = (longint'(1) <<< (CAL_W - 1)) - 1;
    localparam longint CAL_LO       = -(longint'(1) <<< (CAL_W - 1));

    localparam logic signed [OFFSET_W-1:0] OFFSET_HI = {1'b0, {(OFFSET_W-1){1'b1}}};
    localparam logic signed [OFFSET_W-1:0] OFFSET_LO = {1'b1, {(OFFSET_W-1){1'b0}}};
    localparam logic [SCALE_W-1:0]         SCALE_HI  = '1;
    localparam logic [WLEN_W-1:0]          WLEN_HI   = '1;
    localparam logic [SAMPLE_BITS-1:0]     SAMPLE_HI = '1;

    typedef struct {
        logic signed [LVL_W-1:0] level;
        logic signed [CAL_W-1:0] reading;
    } window_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    wrm_sample_if sample_bus ();
    wrm_result_if result_bus ();

    windowed_rms_mean_meter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .din       (sample_bus),
        .dout      (result_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // register shadow, loaded with the reset values
    logic                         cfg_mode   = MODE_RMS;
    logic [WLEN_W-1:0]            cfg_wlen   = WLEN_RST;
    logic [SAMPLE_BITS-1:0]       cfg_center = CENTER_RST;
    logic signed [OFFSET_W-1:0]   cfg_offset = OFFSET_RST;
    logic [SCALE_W-1:0]           cfg_scale  = SCALE_RST;

    // window state
    logic [SUM_W-1:0]      window_sum   = '0;
    logic [COUNT_BITS-1:0] window_count = '0;

    window_result_t pending_results[$];
    int  error_count = 0;
    bit  tx_idle = 1'b1;
    bit  rx_idle = 1'b1;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [SAMPLE_BITS-1:0] random_sample();
        return SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
    endfunction

    function automatic logic [31:0] floor_sqrt(input logic [63:0] value);
        logic [31:0] root;
        logic [31:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (32'd1 << b);
            if (64'(trial) * 64'(trial) <= value)
                root = trial;
        end
        return root;
    endfunction

    // accumulate one sample and queue the window result if the window closes
    function automatic void advance_window(input logic [SAMPLE_BITS-1:0] value);
        longint      centered;
        longint      signed_sum;
        longint      lvl;
        longint      total;
        longint      reading;
        logic [63:0] mean_square;
        centered = longint'(value) - longint'(cfg_center);
        if (cfg_mode == MODE_RMS)
            window_sum = window_sum + SUM_W'(centered * centered);
        else
            window_sum = window_sum + SUM_W'(centered);
        if (window_count != COUNT_MAX)
            window_count = window_count + 1'b1;
        if (window_count < cfg_wlen && window_count != COUNT_MAX)
            return;

        if (cfg_mode == MODE_RMS)
        begin
            mean_square = {window_sum, 16'b0} / 64'(window_count);
            lvl = longint'(floor_sqrt(mean_square));
        end
        else
        begin
            signed_sum = longint'($signed(window_sum));
            lvl = (signed_sum * 256) / longint'(window_count);
        end
        if (lvl > LVL_HI)
            lvl = LVL_HI;
        if (lvl < LVL_LO)
            lvl = LVL_LO;

        total   = lvl + longint'(cfg_offset);
        reading = (total * longint'(cfg_scale)) >>> CAL_SHIFT;
        if (reading > CAL_HI)
            reading = CAL_HI;
        if (reading < CAL_LO)
            reading = CAL_LO;

        pending_results.push_back(window_result_t'{level: LVL_W'(lvl),
                                                   reading: CAL_W'(reading)});
        window_sum   = '0;
        window_count = '0;
    endfunction

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] value);
        int gap;
        gap = tx_idle ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0)
        begin
            sample_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_bus.valid  <= 1'b1;
        sample_bus.sample <= value;
        do @(posedge clk); while (sample_bus.ready !== 1'b1);
        advance_window(value);
    endtask

    // wait until every queued result has come out and the block is quiet
    task automatic settle();
        sample_bus.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input wrm_cfg_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // writes all registers, with junk above the width of each one narrower than cfg_data
    task automatic load_settings(input logic                       mode,
                                 input logic [WLEN_W-1:0]          wlen,
                                 input logic [SAMPLE_BITS-1:0]     center,
                                 input logic signed [OFFSET_W-1:0] offset,
                                 input logic [SCALE_W-1:0]         scale);
        settle();
        put_reg(CFG_MODE,   CFG_DATA_W'({$urandom, mode}));
        put_reg(CFG_WLEN,   CFG_DATA_W'({$urandom, wlen}));
        put_reg(CFG_CENTER, CFG_DATA_W'({$urandom, center}));
        put_reg(CFG_OFFSET, CFG_DATA_W'(offset));
        put_reg(CFG_SCALE,  CFG_DATA_W'({$urandom, scale}));
        cfg_we     <= 1'b0;
        cfg_mode   = mode;
        cfg_wlen   = wlen;
        cfg_center = center;
        cfg_offset = offset;
        cfg_scale  = scale;
    endtask

    // result sink with random stalls between beats
    initial
    begin : result_sink
        int stall;
        result_bus.ready <= 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            stall = rx_idle ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall > 0)
            begin
                result_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_bus.ready <= 1'b1;
            do @(posedge clk); while (result_bus.valid !== 1'b1);
        end
    end

    always @(posedge clk)
    begin : check_results
        window_result_t want;
        if (rst_n && result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result beat: level_q8 %0d, calibrated %0d",
                       result_bus.level_q8, result_bus.calibrated);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_bus.level_q8 !== want.level)
                begin
                    $error("level_q8: expected %0d, got %0d", want.level,
                           result_bus.level_q8);
                    error_count++;
                end
                if (result_bus.calibrated !== want.reading)
                begin
                    $error("calibrated: expected %0d, got %0d", want.reading,
                           result_bus.calibrated);
                    error_count++;
                end
            end
        end
    end

    // a partial window at the register defaults, then only the window
    // length is shortened so the next beat closes it
    task automatic test_reset_defaults();
        logic [WLEN_W-1:0] short_wlen;
        short_wlen = 16'd100;
        tx_idle = 1'b0;
        rx_idle = 1'b1;
        repeat (120) send_sample(random_sample());
        settle();
        put_reg(CFG_WLEN, CFG_DATA_W'(short_wlen));
        cfg_we   <= 1'b0;
        cfg_wlen = short_wlen;
        send_sample(random_sample());
        settle();
    endtask

    task automatic test_field_extremes();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        // zero window length: a result on every beat
        load_settings(MODE_RMS, '0, '0, OFFSET_HI, SCALE_HI);
        send_sample(SAMPLE_HI);
        send_sample('0);
        send_sample(14'd1);
        load_settings(MODE_RMS, 16'd1, SAMPLE_HI, OFFSET_LO, SCALE_HI);
        send_sample('0);
        send_sample(SAMPLE_HI);
        load_settings(MODE_MEAN, '0, 14'd8192, '0, '0);
        send_sample('0);
        send_sample(SAMPLE_HI);
        send_sample(14'd8192);
        // negative mean with a fraction, checks truncation and floor
        load_settings(MODE_MEAN, 16'd3, CENTER_RST, OFFSET_W'(-579), 24'h800000);
        send_sample('0);
        send_sample('0);
        send_sample(14'd1);
        load_settings(MODE_RMS, 16'd3, CENTER_RST, OFFSET_RST, SCALE_RST);
        send_sample(14'd2067);
        send_sample(14'd2068);
        send_sample(14'd2070);
    endtask

    task automatic test_window_shortened();
        logic [SAMPLE_BITS-1:0] center;
        center = random_sample();
        load_settings(MODE_RMS, WLEN_HI, center, '0, SCALE_RST);
        repeat (20) send_sample(random_sample());
        load_settings(MODE_RMS, 16'd5, center, '0, SCALE_RST);
        send_sample(random_sample());
        load_settings(MODE_MEAN, WLEN_HI, center, OFFSET_RST, SCALE_HI);
        repeat (9) send_sample(random_sample());
        load_settings(MODE_MEAN, 16'd2, center, OFFSET_RST, SCALE_HI);
        send_sample(random_sample());
    endtask

    task automatic test_mode_switch();
        // squares read as a mean: level saturates high
        load_settings(MODE_RMS, WLEN_HI, '0, '0, SCALE_HI);
        repeat (3) send_sample(SAMPLE_HI);
        load_settings(MODE_MEAN, 16'd4, '0, '0, SCALE_HI);
        send_sample(SAMPLE_HI);
        // negative sum read as squares wraps huge, root saturates
        load_settings(MODE_MEAN, WLEN_HI, SAMPLE_HI, '0, SCALE_HI);
        repeat (3) send_sample('0);
        load_settings(MODE_RMS, 16'd4, SAMPLE_HI, '0, SCALE_HI);
        send_sample(SAMPLE_HI);
    endtask

    task automatic test_random_windows();
        int                     sent;
        int                     chunk;
        int                     style;
        int                     near;
        logic [WLEN_W-1:0]      wlen;
        logic [SAMPLE_BITS-1:0] center;
        logic [SCALE_W-1:0]     scale;
        logic [SAMPLE_BITS-1:0] value;
        sent = 0;
        while (sent < 1700)
        begin
            case ($urandom_range(0, 9))
                0:       wlen = '0;
                7, 8:    wlen = WLEN_W'($urandom_range(13, 400));
                9:       wlen = WLEN_HI;
                default: wlen = WLEN_W'($urandom_range(1, 12));
            endcase
            case ($urandom_range(0, 5))
                0:       center = '0;
                1:       center = SAMPLE_HI;
                default: center = random_sample();
            endcase
            case ($urandom_range(0, 5))
                0:       scale = '0;
                1:       scale = SCALE_HI;
                default: scale = SCALE_W'($urandom);
            endcase
            // a partly filled window carries over into the new settings
            load_settings(1'($urandom_range(0, 1)), wlen, center,
                          OFFSET_W'($urandom), scale);
            tx_idle = $urandom_range(0, 3) != 0;
            rx_idle = $urandom_range(0, 3) != 0;
            chunk   = $urandom_range(20, 100);
            style   = $urandom_range(0, 3);
            repeat (chunk)
            begin
                near = int'(center) + int'($urandom_range(0, 64)) - 32;
                if (near < 0)
                    near = 0;
                if (near > SAMPLE_MAX)
                    near = SAMPLE_MAX;
                case (style)
                    0:       value = random_sample();
                    1:       value = SAMPLE_BITS'(near);
                    2:       value = $urandom_range(0, 1) ? SAMPLE_HI : '0;
                    default: value = $urandom_range(0, 3) == 0 ? SAMPLE_BITS'(near)
                                     : random_sample();
                endcase
                send_sample(value);
            end
            sent += chunk;
        end
    endtask

    initial
    begin : run_tests
        sample_bus.valid  <= 1'b0;
        sample_bus.sample <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_MODE;
        cfg_data  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_field_extremes();
        test_window_shortened();
        test_mode_switch();
        test_random_windows();
        settle();

        if (error_count == 0)
            $display("[windowed_rms_mean_meter] OK");
        else
            $display("[windowed_rms_mean_meter] ERROR");
        $finish;
    end

    initial
    begin : watchdog
        #20000000;
        $display("[windowed_rms_mean_meter] ERROR");
        $finish;
    end

endmodule
